// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond) \
   `ASSERT_CLK(label, !(cond))

`endif

// File: rtl/u8u16_pkg.sv
// ---------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 transcoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_LEAD  = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;

   localparam logic [15:0] LEAD_BASE  = 16'hD7C0;
   localparam logic [15:0] TRAIL_BASE = 16'hDC00;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] code_unit;
      logic        is_last;
      logic [1:0]  error;
   } result_type;

   typedef struct packed {
      logic [1:0]  push_count;
      result_type  first;
      result_type  second;
   } decode_out_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               room;
   } queue_status_type;

endpackage

`default_nettype wire

// File: rtl/u8u16_if.sv
// ---------------------------------------------------------------------------
// u8u16 channel interfaces
// Valid/ready channels for incoming bytes and outgoing UTF-16 code units.
// ---------------------------------------------------------------------------
`default_nettype none

interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;

   modport source (output valid, output kind, output byte_value, input ready);
   modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        is_last;
   logic [1:0]  error;

   modport source (output valid, output code_unit, output is_last, output error,
                   input ready);
   modport sink   (input valid, input code_unit, input is_last, input error,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/u8u16_decoder.sv
// ---------------------------------------------------------------------------
// u8u16_decoder
// Input register, sequence state and single-pass decode into code units.
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_decoder
   import u8u16_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   u8u16_req_if.sink      req,
   input  wire logic      room,
   output decode_out_type dec_out
);

   logic        in_valid_ff, in_valid_in;
   logic        kind_ff;
   logic [7:0]  byte_ff;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  remaining_ff, remaining_in;
   logic        failed_ff, failed_in;
   logic        consume;
   logic        take;
   logic [20:0] acc_next;
   logic [1:0]  rem_next;

   function automatic decode_out_type emit_cp(input logic [20:0] cp);
      decode_out_type d;
      d = '0;
      if (cp[20:16] != 5'd0) begin
         d.push_count       = 2'd2;
         d.first.code_unit  = LEAD_BASE + {5'd0, cp[20:10]};
         d.second.code_unit = TRAIL_BASE + {6'd0, cp[9:0]};
      end else begin
         d.push_count      = 2'd1;
         d.first.code_unit = cp[15:0];
      end
      return d;
   endfunction

   assign consume     = in_valid_ff && room;
   assign req.ready   = !in_valid_ff || consume;
   assign take        = req.valid && req.ready;
   assign in_valid_in = take || (in_valid_ff && !consume);
   assign acc_next    = {acc_ff[14:0], byte_ff[5:0]};
   assign rem_next    = remaining_ff - 2'd1;

   always_comb begin
      dec_out      = '0;
      acc_in       = acc_ff;
      remaining_in = remaining_ff;
      failed_in    = failed_ff;
      if (consume) begin
         if (kind_ff) begin
            dec_out.push_count    = 2'd1;
            dec_out.first.is_last = 1'b1;
            dec_out.first.error   = (remaining_ff != 2'd0 && !failed_ff) ?
                                    ERR_TRUNCATED : ERR_NONE;
            acc_in       = '0;
            remaining_in = 2'd0;
            failed_in    = 1'b0;
         end else if (failed_ff) begin
            dec_out = '0;
         end else if (remaining_ff != 2'd0) begin
            remaining_in = rem_next;
            if (rem_next == 2'd0) begin
               dec_out = emit_cp(acc_next);
               acc_in  = '0;
            end else begin
               acc_in = acc_next;
            end
         end else if (!byte_ff[7]) begin
            dec_out = emit_cp({14'd0, byte_ff[6:0]});
         end else if (byte_ff[7:5] == 3'b110) begin
            acc_in       = {16'd0, byte_ff[4:0]};
            remaining_in = 2'd1;
         end else if (byte_ff[7:4] == 4'b1110) begin
            acc_in       = {17'd0, byte_ff[3:0]};
            remaining_in = 2'd2;
         end else if (byte_ff[7:3] == 5'b11110) begin
            acc_in       = {18'd0, byte_ff[2:0]};
            remaining_in = 2'd3;
         end else begin
            dec_out.push_count  = 2'd1;
            dec_out.first.error = ERR_BAD_LEAD;
            acc_in              = '0;
            failed_in           = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         remaining_ff <= 2'd0;
         failed_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         acc_ff       <= acc_in;
         remaining_ff <= remaining_in;
         failed_ff    <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= req.kind;
         byte_ff <= req.byte_value;
      end
   end

endmodule

`default_nettype wire

// File: rtl/u8u16_result_queue.sv
// ---------------------------------------------------------------------------
// u8u16_result_queue
// Small result queue taking up to two code units per cycle, issuing one.
// ---------------------------------------------------------------------------
`default_nettype none

module u8u16_result_queue
   import u8u16_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  decode_out_type   dec_in,
   u8u16_rsp_if.source      rsp,
   output queue_status_type status
);

   result_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;
   logic               pop;
   result_type         head;

   assign pop         = rsp.valid && rsp.ready;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + PTR_W'(dec_in.push_count);
   assign rd_ptr_in   = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   assign count_in    = count_ff + COUNT_W'(dec_in.push_count) - COUNT_W'(pop);

   assign status.count = count_ff;
   assign status.room  = count_ff <= COUNT_W'(QUEUE_DEPTH - 2);

   assign head          = entry_ff[rd_ptr_ff];
   assign rsp.valid     = count_ff != '0;
   assign rsp.code_unit = head.code_unit;
   assign rsp.is_last   = head.is_last;
   assign rsp.error     = head.error;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_in.push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= dec_in.first;
      end
      if (dec_in.push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= dec_in.second;
      end
   end

endmodule

`default_nettype wire

// File: rtl/utf8_to_utf16_transcoder.sv
// ---------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Converts a UTF-8 byte stream, closed by an end transaction, into UTF-16.
// ---------------------------------------------------------------------------
// The req channel carries one UTF-8 byte per transaction, or an end marker
// when kind is high. The rsp channel carries one UTF-16 code unit per
// transaction with its last flag and error code.
// A byte is held in an input register, decoded from there once the queue
// has room, and written into a four-entry result queue for the receiver.
// One byte is taken every cycle while the queue holds no more than two
// results, which is set by the queue's two-unit write per cycle against its
// single read port.
// A four-byte sequence ending above the basic plane yields two results
// that are written together and presented one after the other. The end
// transaction yields a zero terminator.
// When the receiver stalls, results wait in the queue and req.ready falls
// once the queue can no longer take a surrogate pair.
// Reset empties the queue and the input register and clears the sequence
// state; req may be driven from the first cycle after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module utf8_to_utf16_transcoder
   import u8u16_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   u8u16_req_if.sink   req_chan,
   u8u16_rsp_if.source rsp_chan
);

   decode_out_type   dec;
   queue_status_type qstat;

   u8u16_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .room    (qstat.room),
      .dec_out (dec)
   );

   u8u16_result_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .dec_in (dec),
      .rsp    (rsp_chan),
      .status (qstat)
   );

   `ASSERT_NEVER(a_count_bound, qstat.count > COUNT_W'(QUEUE_DEPTH))
   `ASSERT_NEVER(a_push_code, dec.push_count == 2'd3)
   `ASSERT_CLK(a_push_needs_room, dec.push_count != 2'd0 |-> qstat.room)
   `ASSERT_CLK(a_pop_drains,
      (rsp_chan.valid && rsp_chan.ready && dec.push_count == 2'd0) |=>
      qstat.count == $past(qstat.count) - COUNT_W'(1))

endmodule

`default_nettype wire

// File: tb/sv/tb_utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Self-checking testbench for the UTF-8 to UTF-16 transcoder. A queue of
// byte and end transactions, first directed and then random strings, feeds
// a clocked driver. A behavioural decoder predicts the UTF-16 code units of
// every accepted transaction, and a clocked monitor compares each result
// transaction with the oldest prediction. Both channels stall at random in the
// first two of three phases, and the receiver once holds off long enough to
// fill the block and stall its input.
// ---------------------------------------------------------------------------

module tb_utf8_to_utf16_transcoder;
   import u8u16_pkg::*;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int RANDOM_ITEMS   = 900;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_LIMIT     = 3000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASE_ONE_FROM = 320;
   localparam int PHASE_TWO_FROM = 640;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } text_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8u16_req_if req_chan ();
   u8u16_rsp_if rsp_chan ();

   utf8_to_utf16_transcoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   text_item_type pending_items[$];
   result_type    expected_units[$];

   logic [20:0] code_point_acc = '0;
   logic [1:0]  continuations_left = '0;
   logic        lead_failed = 1'b0;

   int accepted_bytes = 0;
   int failure_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   function automatic int stall_phase();
      if (accepted_bytes < PHASE_ONE_FROM) begin
         return 0;
      end
      if (accepted_bytes < PHASE_TWO_FROM) begin
         return 1;
      end
      return 2;
   endfunction

   function automatic void push_unit(logic [15:0] unit, logic last, logic [1:0] err);
      result_type r;
      r.code_unit = unit;
      r.is_last   = last;
      r.error     = err;
      expected_units = {expected_units, r};
   endfunction

   function automatic void push_code_point(logic [20:0] cp);
      logic [15:0] lead_unit;
      logic [15:0] trail_unit;
      if (cp > 21'h00FFFF) begin
         lead_unit  = LEAD_BASE + {5'd0, cp[20:10]};
         trail_unit = TRAIL_BASE + {6'd0, cp[9:0]};
         push_unit(lead_unit, 1'b0, ERR_NONE);
         push_unit(trail_unit, 1'b0, ERR_NONE);
      end else begin
         push_unit(cp[15:0], 1'b0, ERR_NONE);
      end
   endfunction

   function automatic void predict_item(logic kind, logic [7:0] b);
      if (kind == KIND_END) begin
         if (continuations_left != 2'd0 && !lead_failed) begin
            push_unit(16'd0, 1'b1, ERR_TRUNCATED);
         end else begin
            push_unit(16'd0, 1'b1, ERR_NONE);
         end
         code_point_acc     = '0;
         continuations_left = '0;
         lead_failed        = 1'b0;
      end else if (lead_failed) begin
      end else if (continuations_left != 2'd0) begin
         code_point_acc     = {code_point_acc[14:0], b[5:0]};
         continuations_left = continuations_left - 2'd1;
         if (continuations_left == 2'd0) begin
            push_code_point(code_point_acc);
            code_point_acc = '0;
         end
      end else if (b[7] == 1'b0) begin
         push_code_point({14'd0, b[6:0]});
      end else if (b[7:5] == 3'b110) begin
         code_point_acc     = {16'd0, b[4:0]};
         continuations_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         code_point_acc     = {17'd0, b[3:0]};
         continuations_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         code_point_acc     = {18'd0, b[2:0]};
         continuations_left = 2'd3;
      end else begin
         lead_failed    = 1'b1;
         code_point_acc = '0;
         push_unit(16'd0, 1'b0, ERR_BAD_LEAD);
      end
   endfunction

   function automatic void queue_item(logic kind, logic [7:0] b);
      text_item_type t;
      t.kind       = kind;
      t.byte_value = b;
      pending_items = {pending_items, t};
   endfunction

   function automatic logic [7:0] lead_byte(int len);
      logic [7:0] r;
      r = 8'($urandom_range(255));
      case (len)
         1: r[7]   = 1'b0;
         2: r[7:5] = 3'b110;
         3: r[7:4] = 4'b1110;
         default: r[7:3] = 5'b11110;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] continuation_byte();
      logic [7:0] r;
      r = 8'($urandom_range(255));
      if ($urandom_range(9) != 0) begin
         r[7:6] = 2'b10;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      text_item_type next_item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_item(req_chan.kind, req_chan.byte_value);
            accepted_bytes++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() != 0 &&
                $urandom_range(99) >= (stall_phase() == 0 ? 25 :
                                       stall_phase() == 1 ? 64 : 0)) begin
               next_item = pending_items.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.kind       <= next_item.kind;
               req_chan.byte_value <= next_item.byte_value;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      result_type actual;
      result_type wanted;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            actual.code_unit = rsp_chan.code_unit;
            actual.is_last   = rsp_chan.is_last;
            actual.error     = rsp_chan.error;
            if (expected_units.size() == 0) begin
               failure_count++;
               if (failure_count <= REPORT_LIMIT) begin
                  $display("unexpected result: code_unit %h is_last %b error %0d",
                           actual.code_unit, actual.is_last, actual.error);
               end
            end else begin
               wanted = expected_units.pop_front();
               if (actual != wanted) begin
                  failure_count++;
                  if (failure_count <= REPORT_LIMIT) begin
                     $display("mismatch: expected %h/%b/%0d, got %h/%b/%0d",
                              wanted.code_unit, wanted.is_last, wanted.error,
                              actual.code_unit, actual.is_last, actual.error);
                  end
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_phase() == 2 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= $urandom_range(99) >= (stall_phase() == 0 ? 64 :
                                                     stall_phase() == 1 ? 25 : 0);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transaction", idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      int chars;
      int len;
      int cut;
      bit truncated;
      req_chan.valid      = 1'b0;
      req_chan.kind       = KIND_BYTE;
      req_chan.byte_value = 8'd0;
      rsp_chan.ready      = 1'b0;

      queue_item(KIND_BYTE, 8'h00);
      queue_item(KIND_BYTE, 8'h7F);
      queue_item(KIND_BYTE, 8'hC2);
      queue_item(KIND_BYTE, 8'hA9);
      queue_item(KIND_BYTE, 8'hE2);
      queue_item(KIND_BYTE, 8'h82);
      queue_item(KIND_BYTE, 8'hAC);
      queue_item(KIND_BYTE, 8'hF0);
      queue_item(KIND_BYTE, 8'h9F);
      queue_item(KIND_BYTE, 8'h98);
      queue_item(KIND_BYTE, 8'h80);
      queue_item(KIND_BYTE, 8'hF7);
      queue_item(KIND_BYTE, 8'hBF);
      queue_item(KIND_BYTE, 8'h7F);
      queue_item(KIND_BYTE, 8'hFF);
      queue_item(KIND_END,  8'hA5);
      queue_item(KIND_BYTE, 8'h80);
      queue_item(KIND_BYTE, 8'h41);
      queue_item(KIND_END,  8'hFF);
      queue_item(KIND_BYTE, 8'hF8);
      queue_item(KIND_END,  8'h00);
      queue_item(KIND_BYTE, 8'hE2);
      queue_item(KIND_BYTE, 8'h82);
      queue_item(KIND_END,  8'h5A);
      queue_item(KIND_END,  8'h00);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         chars     = $urandom_range(1, 12);
         truncated = 1'b0;
         for (int c = 0; c < chars && !truncated; c++) begin
            case ($urandom_range(99)) inside
               [0:5]: begin
                  queue_item(KIND_BYTE, 8'($urandom_range(255)));
                  counted++;
               end
               [6:9]: begin
                  len = $urandom_range(2, 4);
                  cut = $urandom_range(0, len - 2);
                  queue_item(KIND_BYTE, lead_byte(len));
                  counted++;
                  for (int k = 0; k < cut; k++) begin
                     queue_item(KIND_BYTE, continuation_byte());
                     counted++;
                  end
                  truncated = 1'b1;
               end
               default: begin
                  len = $urandom_range(1, 4);
                  queue_item(KIND_BYTE, lead_byte(len));
                  counted++;
                  for (int k = 1; k < len; k++) begin
                     queue_item(KIND_BYTE, continuation_byte());
                     counted++;
                  end
               end
            endcase
         end
         queue_item(KIND_END, 8'($urandom_range(255)));
         counted++;
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_chan.valid) @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_units.size() != 0) begin
         failure_count++;
      end
      if (failure_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/u8u16_pkg.sv
rtl/u8u16_if.sv
rtl/u8u16_decoder.sv
rtl/u8u16_result_queue.sv
rtl/utf8_to_utf16_transcoder.sv
tb/sv/tb_utf8_to_utf16_transcoder.sv
